### hw/rtl/imu_bias_calibrate_and_correct_core_defines.svh
// ----------------------------------------------------------------------------
// imu bias calibrate and correct: assertion macros
// shared concurrent assertion forms, clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef IMU_BIAS_CALIBRATE_AND_CORRECT_CORE_DEFINES_SVH
`define IMU_BIAS_CALIBRATE_AND_CORRECT_CORE_DEFINES_SVH

// same-cycle implication
`define IBCC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IBCC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/ibcc_pkg.sv
// ----------------------------------------------------------------------------
// ibcc_pkg
// constants and types shared by the imu bias calibrate and correct block
// ----------------------------------------------------------------------------
package ibcc_pkg;

   localparam int AXES        = 6;
   localparam int AXIS_ACC_Z  = 2;
   localparam int SAMPLE_W    = 16;
   localparam int SUM_W       = 32;
   localparam int ONE_G_W     = 15;
   localparam int CNT_W       = 16;
   localparam int CAL_SAMPLES = 256;
   localparam int DIVISOR     = CAL_SAMPLES - 1;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // floor(n / DIVISOR) = (n * DIV_MUL) >> DIV_SHIFT for any n below 2**SUM_W
   localparam int DIV_SHIFT   = SUM_W + $clog2(DIVISOR);
   localparam int MUL_W       = SUM_W + 1;
   localparam int MUL_LO_W    = 16;
   localparam int MUL_HI_W    = MUL_W - MUL_LO_W;
   localparam int PROD_W      = SUM_W + MUL_HI_W;
   localparam int ACC_W       = SUM_W + MUL_W;

   localparam logic [MUL_W-1:0] DIV_MUL =
      MUL_W'(((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

   localparam logic [CNT_W-1:0] CAL_CNT = CNT_W'(CAL_SAMPLES);

   localparam logic [CSR_IDX_W-1:0] CSR_SKIP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_G  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_AX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_AY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_AZ = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_GX = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_GY = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_GZ = 3'd7;

   localparam logic [ONE_G_W-1:0] ONE_G_RESET = ONE_G_W'(2048);

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum logic [1:0] {
      OFFS_HELD,
      OFFS_QUOT,
      OFFS_PRESET
   } offs_sel_type;

   typedef struct packed {
      logic         clear;
      logic         add;
      logic         corr;
      offs_sel_type sel;
   } lane_ctl_type;

   typedef struct packed {
      sample_type [AXES-1:0] axis;
      logic                  corrected;
   } result_type;

endpackage

### hw/rtl/ibcc_if.sv
// ----------------------------------------------------------------------------
// ibcc channel interfaces
// valid/ready channels for raw samples and corrected results
// ----------------------------------------------------------------------------
interface ibcc_req_if;
   import ibcc_pkg::*;

   logic       valid;
   logic       ready;
   sample_type acc_x_raw;
   sample_type acc_y_raw;
   sample_type acc_z_raw;
   sample_type gyr_x_raw;
   sample_type gyr_y_raw;
   sample_type gyr_z_raw;

   modport source (
      output valid, acc_x_raw, acc_y_raw, acc_z_raw, gyr_x_raw, gyr_y_raw, gyr_z_raw,
      input  ready
   );
   modport sink (
      input  valid, acc_x_raw, acc_y_raw, acc_z_raw, gyr_x_raw, gyr_y_raw, gyr_z_raw,
      output ready
   );
endinterface

interface ibcc_rsp_if;
   import ibcc_pkg::*;

   logic       valid;
   logic       ready;
   sample_type acc_x_out;
   sample_type acc_y_out;
   sample_type acc_z_out;
   sample_type gyr_x_out;
   sample_type gyr_y_out;
   sample_type gyr_z_out;
   logic       corrected;

   modport source (
      output valid, acc_x_out, acc_y_out, acc_z_out, gyr_x_out, gyr_y_out, gyr_z_out,
      output corrected,
      input  ready
   );
   modport sink (
      input  valid, acc_x_out, acc_y_out, acc_z_out, gyr_x_out, gyr_y_out, gyr_z_out,
      input  corrected,
      output ready
   );
endinterface

### hw/rtl/ibcc_lane.sv
// ----------------------------------------------------------------------------
// ibcc_lane
// one axis: bias sum, reciprocal-multiply signed divide, offset hold and
// subtract
// ----------------------------------------------------------------------------
module ibcc_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  ibcc_pkg::lane_ctl_type              ctl,
   input  logic                                div_go,
   input  ibcc_pkg::sample_type                raw,
   input  logic [ibcc_pkg::ONE_G_W-1:0]        bias,
   input  ibcc_pkg::sample_type                preset,
   output ibcc_pkg::sample_type                result,
   output logic                                div_busy
);
   import ibcc_pkg::*;

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W-1:0]    delta;
   logic                busy_ff, busy_in;
   logic                step_ff, step_in;
   logic [SUM_W-1:0]    mag_ff, mag_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic                neg_ff, neg_in;
   logic [MUL_HI_W-1:0] mul_k;
   logic [PROD_W-1:0]   prod;
   logic [SAMPLE_W-1:0] quo;
   sample_type          quot;
   sample_type          offs_use;
   sample_type          off_ff, off_in;

   assign delta = {{(SUM_W-SAMPLE_W){raw[SAMPLE_W-1]}}, raw}
                - {{(SUM_W-ONE_G_W){1'b0}}, bias};

   always_comb begin
      sum_in = sum_ff;
      if (accept && ctl.clear) begin
         sum_in = '0;
      end else if (accept && ctl.add) begin
         sum_in = sum_ff + delta;
      end
   end

   // |sum| times the divisor reciprocal, low half of the constant first
   assign mul_k = step_ff ? DIV_MUL[MUL_W-1:MUL_LO_W] : MUL_HI_W'(DIV_MUL[MUL_LO_W-1:0]);
   assign prod  = PROD_W'(mag_ff) * PROD_W'(mul_k);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      mag_in  = mag_ff;
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      if (div_go) begin
         busy_in = 1'b1;
         step_in = 1'b0;
         neg_in  = sum_ff[SUM_W-1];
         mag_in  = sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
      end else if (busy_ff) begin
         if (!step_ff) begin
            acc_in  = ACC_W'(prod);
            step_in = 1'b1;
         end else begin
            acc_in  = acc_ff + {prod, {MUL_LO_W{1'b0}}};
            busy_in = 1'b0;
         end
      end
   end

   assign quo  = acc_ff[DIV_SHIFT +: SAMPLE_W];
   assign quot = neg_ff ? (~quo + 1'b1) : quo;

   always_comb begin
      unique case (ctl.sel)
         OFFS_HELD:   offs_use = off_ff;
         OFFS_QUOT:   offs_use = quot;
         OFFS_PRESET: offs_use = preset;
         default:     offs_use = off_ff;
      endcase
   end

   assign off_in   = (accept && ctl.corr) ? offs_use : off_ff;
   assign result   = ctl.corr ? (raw - offs_use) : raw;
   assign div_busy = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         off_ff  <= '0;
         busy_ff <= 1'b0;
         step_ff <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         off_ff  <= off_in;
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      mag_ff <= mag_in;
      acc_ff <= acc_in;
      neg_ff <= neg_in;
   end

endmodule

### hw/rtl/ibcc_merge.sv
// ----------------------------------------------------------------------------
// ibcc_merge
// gathers the lane results into one result and holds it in an output
// register backed by a skid entry
// ----------------------------------------------------------------------------
module ibcc_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  ibcc_pkg::result_type   item,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output ibcc_pkg::result_type   rsp_item,
   output logic                   skid_full
);
   import ibcc_pkg::*;

   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       take;

   assign take = out_valid_ff && rsp_ready;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (accept) begin
         if (!out_valid_ff || take) begin
            out_in       = item;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = item;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;
   assign skid_full = skid_valid_ff;

endmodule

### hw/rtl/imu_bias_calibrate_and_correct_core.sv
// ----------------------------------------------------------------------------
// imu_bias_calibrate_and_correct_core
// six-axis static bias calibration and correction
//
//   channel | direction | payload
//   req     | in        | acc_x/y/z_raw, gyr_x/y/z_raw
//   rsp     | out       | acc_x/y/z_out, gyr_x/y/z_out, corrected
//   csr     | in        | csr_we, csr_index, csr_wdata
//
// one transaction per cycle while req.ready is high; a result is registered in the
// output register as its transaction is taken, or in a skid entry that takes one more
// transaction while rsp stalls, then req drops ready
// the sample that finishes calibration is stalled after the last summed sample while
// go starts the lane dividers and they run their two multiply steps
// reset clears the calibration state and configuration registers; no clearing pass
// ----------------------------------------------------------------------------
module imu_bias_calibrate_and_correct_core (
   input  logic                               clock,
   input  logic                               reset,
   ibcc_req_if.sink                           req,
   ibcc_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [ibcc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ibcc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ibcc_pkg::*;

   logic                skip_ff, skip_in;
   logic [ONE_G_W-1:0]  one_g_ff, one_g_in;
   sample_type          preset_ff [AXES];
   sample_type          preset_in [AXES];

   logic                cal_ff, cal_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    cnt_inc;
   logic                go_ff, go_in;
   logic                go_next;
   lane_ctl_type        ctl;
   logic                hold;
   logic                accept;
   logic                skid_full;
   logic [AXES-1:0]     busy;
   sample_type          raw [AXES];
   sample_type          lane_res [AXES];
   result_type          item;
   result_type          rsp_item;

   // configuration writes
   always_comb begin
      skip_in   = skip_ff;
      one_g_in  = one_g_ff;
      preset_in = preset_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SKIP:   skip_in      = csr_wdata[0];
            CSR_ONE_G:  one_g_in     = csr_wdata[ONE_G_W-1:0];
            CSR_PRE_AX: preset_in[0] = csr_wdata;
            CSR_PRE_AY: preset_in[1] = csr_wdata;
            CSR_PRE_AZ: preset_in[2] = csr_wdata;
            CSR_PRE_GX: preset_in[3] = csr_wdata;
            CSR_PRE_GY: preset_in[4] = csr_wdata;
            CSR_PRE_GZ: preset_in[5] = csr_wdata;
            default:    skip_in      = skip_ff;
         endcase
      end
   end

   // calibration sequencing
   assign cnt_inc = cnt_ff + 1'b1;

   always_comb begin
      ctl     = '{clear: 1'b0, add: 1'b0, corr: 1'b0, sel: OFFS_HELD};
      cal_in  = cal_ff;
      cnt_in  = cnt_ff;
      go_next = 1'b0;
      priority if (cal_ff) begin
         ctl.corr = 1'b1;
      end else if (skip_ff) begin
         ctl.corr = 1'b1;
         ctl.sel  = OFFS_PRESET;
         cal_in   = 1'b1;
      end else if (cnt_ff == '0) begin
         ctl.clear = 1'b1;
         cnt_in    = CNT_W'(1);
      end else if (cnt_ff < CAL_CNT) begin
         ctl.add = 1'b1;
         cnt_in  = cnt_inc;
         go_next = (cnt_inc == CAL_CNT);
      end else if (cnt_ff == CAL_CNT) begin
         ctl.corr = 1'b1;
         ctl.sel  = OFFS_QUOT;
         cal_in   = 1'b1;
         cnt_in   = '0;
      end else begin
         ctl.corr = 1'b0;
      end
   end

   assign hold      = !cal_ff && !skip_ff && (cnt_ff == CAL_CNT) && (go_ff || (|busy));
   assign req.ready = !skid_full && !hold;
   assign accept    = req.valid && req.ready;
   assign go_in     = accept && go_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff   <= 1'b0;
         one_g_ff  <= ONE_G_RESET;
         preset_ff <= '{default: '0};
         cal_ff    <= 1'b0;
         cnt_ff    <= '0;
         go_ff     <= 1'b0;
      end else begin
         skip_ff   <= skip_in;
         one_g_ff  <= one_g_in;
         preset_ff <= preset_in;
         cal_ff    <= accept ? cal_in : cal_ff;
         cnt_ff    <= accept ? cnt_in : cnt_ff;
         go_ff     <= go_in;
      end
   end

   // lanes
   always_comb begin
      raw[0] = req.acc_x_raw;
      raw[1] = req.acc_y_raw;
      raw[2] = req.acc_z_raw;
      raw[3] = req.gyr_x_raw;
      raw[4] = req.gyr_y_raw;
      raw[5] = req.gyr_z_raw;
   end

   for (genvar i = 0; i < AXES; i++) begin : g_lane
      ibcc_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .accept   (accept),
         .ctl      (ctl),
         .div_go   (go_ff),
         .raw      (raw[i]),
         .bias     ((i == AXIS_ACC_Z) ? one_g_ff : '0),
         .preset   (preset_ff[i]),
         .result   (lane_res[i]),
         .div_busy (busy[i])
      );
   end

   always_comb begin
      for (int k = 0; k < AXES; k++) item.axis[k] = lane_res[k];
      item.corrected = ctl.corr;
   end

   ibcc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (item),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .rsp_item  (rsp_item),
      .skid_full (skid_full)
   );

   assign rsp.acc_x_out = rsp_item.axis[0];
   assign rsp.acc_y_out = rsp_item.axis[1];
   assign rsp.acc_z_out = rsp_item.axis[2];
   assign rsp.gyr_x_out = rsp_item.axis[3];
   assign rsp.gyr_y_out = rsp_item.axis[4];
   assign rsp.gyr_z_out = rsp_item.axis[5];
   assign rsp.corrected = rsp_item.corrected;

endmodule

### hw/rtl/ibcc_checker.sv
// ----------------------------------------------------------------------------
// ibcc_checker
// port-level checks on the result channel, bound to the core
// ----------------------------------------------------------------------------
`include "imu_bias_calibrate_and_correct_core_defines.svh"

module ibcc_checker (
   input logic        clock,
   input logic        reset,
   ibcc_rsp_if.source rsp
);
   import ibcc_pkg::*;

   logic                     seen_corr_ff, seen_corr_in;
   logic                     rsp_stall;
   logic [AXES*SAMPLE_W:0]   rsp_payload;

   // once a corrected transaction is delivered, all later ones are corrected
   assign seen_corr_in = seen_corr_ff || (rsp.valid && rsp.ready && rsp.corrected);

   assign rsp_stall   = rsp.valid && !rsp.ready;
   assign rsp_payload = {rsp.acc_x_out, rsp.acc_y_out, rsp.acc_z_out,
                         rsp.gyr_x_out, rsp.gyr_y_out, rsp.gyr_z_out, rsp.corrected};

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_corr_ff <= 1'b0;
      end else begin
         seen_corr_ff <= seen_corr_in;
      end
   end

   `IBCC_ASSERT_NEXT(a_rsp_valid_hold, rsp_stall, rsp.valid, "rsp valid dropped")
   `IBCC_ASSERT_NEXT(a_rsp_data_hold, rsp_stall, $stable(rsp_payload), "rsp payload changed")
   `IBCC_ASSERT_IMPL(a_corr_sticky, rsp.valid && seen_corr_ff, rsp.corrected, "uncorrected after calibration")
   `IBCC_ASSERT_IMPL(a_empty_after_reset, $past(reset), !rsp.valid, "rsp valid right after reset")

endmodule

bind imu_bias_calibrate_and_correct_core ibcc_checker u_ibcc_checker (
   .clock (clock),
   .reset (reset),
   .rsp   (rsp)
);
